[sv/nstd_pkg.sv]
// Shared types and constants for the noise-shaped TPDF dither requantizer.
package nstd_pkg;

   localparam int CH_W     = 3;
   localparam int SAMPLE_W = 32;
   localparam int NOISE_W  = 15;
   localparam int OUT_W    = 24;
   localparam int OBITS_W  = 5;
   localparam int GAIN_W   = 16;
   localparam int ERR_W    = 36;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   localparam logic [OBITS_W-1:0] OBITS_MIN   = 5'd1;
   localparam logic [OBITS_W-1:0] OBITS_MAX   = 5'd24;
   localparam logic [OBITS_W-1:0] OBITS_RESET = 5'd16;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd0;

   // Register index, taken from paddr[2]
   typedef enum logic [0:0] {
      REG_OUTPUT_BITS  = 1'b0,
      REG_SHAPING_GAIN = 1'b1
   } reg_idx_type;

   typedef struct packed {
      logic [OBITS_W-1:0] output_bits;
      logic [GAIN_W-1:0]  shaping_gain;
   } cfg_type;

   // Per-channel history: previous noise word and two error terms (Q.31 units)
   typedef struct packed {
      logic [NOISE_W-1:0] last_noise;
      logic [ERR_W-1:0]   err_new;
      logic [ERR_W-1:0]   err_old;
   } hist_type;

endpackage

[sv/nstd_csr.sv]
// APB-style configuration registers: output word length and shaping gain.
module nstd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [nstd_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [nstd_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [nstd_pkg::DATA_W-1:0]  csr_prdata,
   output nstd_pkg::cfg_type            cfg
);
   import nstd_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type reg_sel;
   logic        wr_en;

   assign reg_sel = reg_idx_type'(csr_paddr[2]);
   assign wr_en   = csr_psel && csr_penable && csr_pwrite;

   // next register values
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_OUTPUT_BITS:  cfg_in.output_bits  = csr_pwdata[OBITS_W-1:0];
            REG_SHAPING_GAIN: cfg_in.shaping_gain = csr_pwdata[GAIN_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.output_bits  <= OBITS_RESET;
         cfg_ff.shaping_gain <= GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         REG_OUTPUT_BITS:  csr_prdata = DATA_W'(cfg_ff.output_bits);
         REG_SHAPING_GAIN: csr_prdata = DATA_W'(cfg_ff.shaping_gain);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[sv/nstd_hist.sv]
// Per-channel history memory with valid bits, registered read and write bypass.
module nstd_hist #(
   parameter int CHANNELS = 8,
   parameter int IDX_W    = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_idx,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_idx,
   input  nstd_pkg::hist_type   wr_data,
   output nstd_pkg::hist_type   rd_data
);
   import nstd_pkg::*;

   hist_type              mem [CHANNELS];
   logic [CHANNELS-1:0]   vld_ff;
   hist_type              rd_data_ff;

   // valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // registered read; a same-cycle write to the same entry is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_idx == rd_idx)) begin
            rd_data_ff <= wr_data;
         end else if (vld_ff[rd_idx]) begin
            rd_data_ff <= mem[rd_idx];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/nstd_calc.sv]
// Requantizer datapath: error feedback, dither, floor, saturation, new error.
module nstd_calc (
   input  nstd_pkg::cfg_type                     cfg,
   input  logic                                  ch_ok,
   input  logic signed [nstd_pkg::SAMPLE_W-1:0]  sample_in,
   input  logic [nstd_pkg::NOISE_W-1:0]          noise,
   input  nstd_pkg::hist_type                    hist,
   output nstd_pkg::hist_type                    hist_new,
   output logic signed [nstd_pkg::OUT_W-1:0]     sample_out,
   output logic                                  clipped
);
   import nstd_pkg::*;

   logic [OBITS_W-1:0]       bits;
   logic [OBITS_W-1:0]       shamt;
   logic signed [ERR_W-1:0]  e1;
   logic signed [ERR_W-1:0]  e2;
   logic [NOISE_W-1:0]       prev;
   logic signed [37:0]       fb_arg;
   logic signed [54:0]       prod;
   logic signed [40:0]       fb;
   logic signed [40:0]       d;
   logic signed [15:0]       ndiff;
   logic signed [47:0]       dither;
   logic signed [47:0]       half;
   logic signed [47:0]       lsb_mask;
   logic signed [47:0]       t;
   logic signed [47:0]       q;
   logic signed [47:0]       err;
   logic signed [47:0]       qmax;
   logic signed [47:0]       qmin;
   logic signed [47:0]       qs;

   always_comb begin
      // effective word length and LSB position
      if (cfg.output_bits < OBITS_MIN) begin
         bits = OBITS_MIN;
      end else if (cfg.output_bits > OBITS_MAX) begin
         bits = OBITS_MAX;
      end else begin
         bits = cfg.output_bits;
      end
      shamt = OBITS_W'(6'd32 - {1'b0, bits});

      // history, zero for channels outside the store
      e1   = ch_ok ? $signed(hist.err_new) : '0;
      e2   = ch_ok ? $signed(hist.err_old) : '0;
      prev = ch_ok ? hist.last_noise : '0;

      // second-order error feedback, gain in Q1.15
      fb_arg = (38'(e1) <<< 1) - 38'(e2);
      prod   = $signed({1'b0, cfg.shaping_gain}) * fb_arg;
      fb     = 41'(prod >>> 15);
      d      = 41'(sample_in) + fb;

      // high-pass triangular dither scaled to one output LSB
      ndiff  = $signed({1'b0, noise}) - $signed({1'b0, prev});
      dither = (48'(ndiff) <<< shamt) >>> 15;

      half     = 48'sd1 <<< (shamt - 5'd1);
      lsb_mask = (48'sd1 <<< shamt) - 48'sd1;
      t        = 48'(d) + half + dither;
      q        = t >>> shamt;
      err      = 48'(d) - (t & ~lsb_mask);

      // saturate to the word length
      qmax = (48'sd1 <<< (bits - 5'd1)) - 48'sd1;
      qmin = ~qmax;
      if (q > qmax) begin
         qs      = qmax;
         clipped = 1'b1;
      end else if (q < qmin) begin
         qs      = qmin;
         clipped = 1'b1;
      end else begin
         qs      = q;
         clipped = 1'b0;
      end
      sample_out = qs[OUT_W-1:0];

      hist_new.last_noise = noise;
      hist_new.err_new    = err[ERR_W-1:0];
      hist_new.err_old    = e1;
   end

endmodule

[sv/noise_shaped_tpdf_dither.sv]
// Noise-shaped TPDF dither requantizer: one input register, one result register.
// The rsp_ ports show the result register. Throughput: one request per cycle
// while rsp_ready does not stall; same-channel requests may follow back to back
// since the history read is registered with forwarding from the write-back.
// Reset (synchronous, active high) clears pipeline valids, the history valid bits
// (all history reads as zero) and sets output_bits to 16, shaping_gain to 0.
module noise_shaped_tpdf_dither #(
   parameter int CHANNELS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [nstd_pkg::CH_W-1:0]             req_channel,
   input  logic signed [nstd_pkg::SAMPLE_W-1:0]  req_sample_in,
   input  logic [nstd_pkg::NOISE_W-1:0]          req_noise,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [nstd_pkg::CH_W-1:0]             rsp_channel_out,
   output logic signed [nstd_pkg::OUT_W-1:0]     rsp_sample_out,
   output logic                                  rsp_clipped,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [nstd_pkg::ADDR_W-1:0]           csr_paddr,
   input  logic [nstd_pkg::DATA_W-1:0]           csr_pwdata,
   output logic [nstd_pkg::DATA_W-1:0]           csr_prdata,
   output logic                                  csr_pready
);
   import nstd_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   cfg_type                  cfg;
   hist_type                 hist_rd;
   hist_type                 hist_new;

   logic                     s1_vld_ff, s1_vld_in;
   logic [CH_W-1:0]          s1_ch_ff;
   logic                     s1_chok_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic [NOISE_W-1:0]       s1_noise_ff;

   logic                     out_vld_ff, out_vld_in;
   logic [CH_W-1:0]          out_ch_ff;
   logic signed [OUT_W-1:0]  out_sample_ff;
   logic                     out_clip_ff;

   logic                     out_free;
   logic                     s1_adv;
   logic                     accept;
   logic                     req_chok;
   logic signed [OUT_W-1:0]  calc_sample;
   logic                     calc_clip;

   // handshake
   assign out_free  = !out_vld_ff || rsp_ready;
   assign s1_adv    = s1_vld_ff && out_free;
   assign req_ready = !s1_vld_ff || out_free;
   assign accept    = req_valid && req_ready;
   assign req_chok  = int'(req_channel) < CHANNELS;

   assign s1_vld_in  = accept || (s1_vld_ff && !out_free);
   assign out_vld_in = s1_adv || (out_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ch_ff     <= req_channel;
         s1_chok_ff   <= req_chok;
         s1_sample_ff <= req_sample_in;
         s1_noise_ff  <= req_noise;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_ch_ff     <= s1_ch_ff;
         out_sample_ff <= calc_sample;
         out_clip_ff   <= calc_clip;
      end
   end

   nstd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   nstd_hist #(
      .CHANNELS (CHANNELS),
      .IDX_W    (IDX_W)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && req_chok),
      .rd_idx  (IDX_W'(req_channel)),
      .wr_en   (s1_adv && s1_chok_ff),
      .wr_idx  (IDX_W'(s1_ch_ff)),
      .wr_data (hist_new),
      .rd_data (hist_rd)
   );

   nstd_calc u_calc (
      .cfg        (cfg),
      .ch_ok      (s1_chok_ff),
      .sample_in  (s1_sample_ff),
      .noise      (s1_noise_ff),
      .hist       (hist_rd),
      .hist_new   (hist_new),
      .sample_out (calc_sample),
      .clipped    (calc_clip)
   );

   assign rsp_valid       = out_vld_ff;
   assign rsp_channel_out = out_ch_ff;
   assign rsp_sample_out  = out_sample_ff;
   assign rsp_clipped     = out_clip_ff;
   assign csr_pready      = 1'b1;

endmodule

[sim/noise_shaped_tpdf_dither_tb.sv]
// Self-checking testbench for the noise-shaped TPDF dither requantizer.
`timescale 1ns / 1ps

module noise_shaped_tpdf_dither_tb;
   import nstd_pkg::*;

   localparam int CHANNELS     = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 6;
   localparam int IDLE_MAX     = 18;

   // One expected requantized result
   typedef struct {
      logic [CH_W-1:0]         channel;
      logic signed [OUT_W-1:0] code;
      logic                    clipped;
   } requant_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [CH_W-1:0]            req_channel;
   logic signed [SAMPLE_W-1:0] req_sample_in;
   logic [NOISE_W-1:0]         req_noise;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [CH_W-1:0]            rsp_channel_out;
   logic signed [OUT_W-1:0]    rsp_sample_out;
   logic                       rsp_clipped;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [ADDR_W-1:0]          csr_paddr;
   logic [DATA_W-1:0]          csr_pwdata;
   logic [DATA_W-1:0]          csr_prdata;
   logic                       csr_pready;

   // Configuration and per-channel history as the block should hold them
   logic [OBITS_W-1:0]      obits_cfg = OBITS_RESET;
   logic [GAIN_W-1:0]       gain_cfg  = GAIN_RESET;
   logic [NOISE_W-1:0]      hist_noise   [CHANNELS];
   logic signed [ERR_W-1:0] hist_err_new [CHANNELS];
   logic signed [ERR_W-1:0] hist_err_old [CHANNELS];

   requant_type pending_codes [$];
   int          mismatch_count = 0;
   int          cycle_count    = 0;
   int          idle_max       = IDLE_MAX;

   noise_shaped_tpdf_dither #(.CHANNELS(CHANNELS)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_channel     (req_channel),
      .req_sample_in   (req_sample_in),
      .req_noise       (req_noise),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_channel_out (rsp_channel_out),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_clipped     (rsp_clipped),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // Clock
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Requantize one request and update the channel history; queue the result
   function automatic void predict_requant(input logic [CH_W-1:0] ch,
                                           input logic signed [SAMPLE_W-1:0] smp,
                                           input logic [NOISE_W-1:0] nz);
      int unsigned bits;
      int unsigned sh;
      longint      lsb, e1, e2, prev, d, dith, t, q, qmax, qmin, qs;
      logic        clip;
      requant_type r;
      bits = 32'(obits_cfg);
      if (bits < 1) bits = 1;
      if (bits > 24) bits = 24;
      sh   = 32 - bits;
      lsb  = 64'sd1 << sh;
      e1   = longint'(hist_err_new[ch]);
      e2   = longint'(hist_err_old[ch]);
      prev = longint'(hist_noise[ch]);
      // error feedback, then half-LSB offset and high-pass triangular dither
      d    = longint'(smp) + ((longint'(gain_cfg) * (2 * e1 - e2)) >>> 15);
      dith = ((longint'(nz) - prev) * lsb) >>> 15;
      t    = d + (lsb >>> 1) + dith;
      q    = t >>> sh;
      // saturate; history keeps the unsaturated code
      qmax = (64'sd1 << (bits - 1)) - 1;
      qmin = -(64'sd1 << (bits - 1));
      qs   = q;
      clip = 1'b0;
      if (qs > qmax) begin
         qs   = qmax;
         clip = 1'b1;
      end else if (qs < qmin) begin
         qs   = qmin;
         clip = 1'b1;
      end
      hist_err_old[ch] = ERR_W'(e1);
      hist_err_new[ch] = ERR_W'(d - q * lsb);
      hist_noise[ch]   = nz;
      r.channel = ch;
      r.code    = qs[OUT_W-1:0];
      r.clipped = clip;
      pending_codes.push_back(r);
   endfunction

   // Send one request; called at a falling edge, returns at a falling edge
   task automatic send_request(input logic [CH_W-1:0] ch,
                               input logic signed [SAMPLE_W-1:0] smp,
                               input logic [NOISE_W-1:0] nz);
      int gap;
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_channel   = ch;
      req_sample_in = smp;
      req_noise     = nz;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      predict_requant(ch, smp, nz);
      @(negedge clock);
   endtask

   // Stop sending and let every outstanding result come back
   task automatic wait_for_drain();
      req_valid = 1'b0;
      while (pending_codes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Register write: setup phase, then access phase; block must be idle
   task automatic csr_write(input reg_idx_type idx, input logic [DATA_W-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      if (idx == REG_OUTPUT_BITS)
         obits_cfg = value[OBITS_W-1:0];
      else
         gain_cfg = value[GAIN_W-1:0];
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic set_config(input logic [OBITS_W-1:0] obits, input logic [GAIN_W-1:0] gain);
      csr_write(REG_OUTPUT_BITS, DATA_W'(obits));
      csr_write(REG_SHAPING_GAIN, DATA_W'(gain));
   endtask

   // Random sample: full scale, near either rail, or near zero
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int unsigned off;
      off = $urandom_range(0, 1 << $urandom_range(2, 24));
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'sh7FFF_FFFF - off;
         2: return 32'sh8000_0000 + off;
         default: return $signed(off) - (1 << 20);
      endcase
   endfunction

   // Random noise, with the extremes drawn more often
   function automatic logic [NOISE_W-1:0] pick_noise();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return NOISE_W'($urandom_range(0, 32767));
      endcase
   endfunction

   // Compare each accepted result with the oldest expectation
   task automatic check_result();
      requant_type want;
      if (pending_codes.size() == 0) begin
         $display("%0t: unexpected result channel %0d sample %0d clipped %0b",
                  $time, rsp_channel_out, rsp_sample_out, rsp_clipped);
         mismatch_count++;
         return;
      end
      want = pending_codes.pop_front();
      if (rsp_channel_out !== want.channel) begin
         $display("%0t: channel_out expected %0d actual %0d",
                  $time, want.channel, rsp_channel_out);
         mismatch_count++;
      end
      if (rsp_sample_out !== want.code) begin
         $display("%0t: sample_out expected %0d actual %0d",
                  $time, want.code, rsp_sample_out);
         mismatch_count++;
      end
      if (rsp_clipped !== want.clipped) begin
         $display("%0t: clipped expected %0b actual %0b",
                  $time, want.clipped, rsp_clipped);
         mismatch_count++;
      end
   endtask

   // Result side: random stall before each result
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = $urandom_range(0, idle_max);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         check_result();
         @(negedge clock);
      end
   end

   // Reset configuration: 16 bits, no feedback; rails, dither extremes, saturation
   task automatic test_reset_defaults();
      send_request(3'd0, 32'sd0, 15'd0);
      send_request(3'd0, 32'sd0, 15'd32767);
      send_request(3'd0, 32'sd0, 15'd0);
      send_request(3'd1, 32'sh7FFF_FFFF, 15'd32767);
      send_request(3'd2, 32'sh8000_0000, 15'd0);
      send_request(3'd3, 32'sh8000_0000, 15'd32767);
      send_request(3'd3, 32'sh8000_0000, 15'd0);
      send_request(3'd7, 32'sh0000_8000, 15'd16384);
      send_request(3'd4, -32'sd1, 15'd1);
      send_request(3'd6, 32'sh7FFF_8000, 15'd0);
   endtask

   // Word length zero acts as one, above 24 acts as 24
   task automatic test_word_length_limits();
      wait_for_drain();
      set_config(5'd0, GAIN_RESET);
      send_request(3'd5, 32'sh7FFF_FFFF, 15'd32767);
      send_request(3'd5, 32'sh8000_0000, 15'd0);
      send_request(3'd5, 32'sd0, 15'd12345);
      wait_for_drain();
      set_config(5'd31, GAIN_RESET);
      send_request(3'd6, 32'sh7FFF_FFFF, 15'd32767);
      send_request(3'd6, -32'sd1, 15'd0);
      send_request(3'd6, 32'sh0000_0080, 15'd20000);
   endtask

   // Feedback gain of one and just under two on one channel
   task automatic test_gain_above_one();
      wait_for_drain();
      set_config(5'd8, 16'hFFFF);
      send_request(3'd1, 32'sh0012_3456, 15'd30000);
      send_request(3'd1, 32'sh0012_3456, 15'd100);
      send_request(3'd1, -32'sh0031_0000, 15'd32767);
      send_request(3'd1, 32'sh7FFF_FFFF, 15'd0);
      wait_for_drain();
      set_config(OBITS_MAX, 16'h8000);
      send_request(3'd1, 32'sh0000_0123, 15'd777);
      send_request(3'd1, -32'sh0000_0123, 15'd31000);
   endtask

   // Random traffic in phases with different settings and idle patterns
   task automatic test_random_traffic();
      int                 phase, k, ch_hi;
      logic [OBITS_W-1:0] obits;
      logic [GAIN_W-1:0]  gain;
      for (phase = 0; phase < 12; phase++) begin
         case (phase)
            0: begin obits = OBITS_RESET; gain = 16'd0;     end
            1: begin obits = OBITS_MIN;   gain = 16'h8000;  end
            2: begin obits = OBITS_MAX;   gain = 16'hFFFF;  end
            3: begin obits = 5'd0;        gain = 16'h4000;  end
            4: begin obits = 5'd31;       gain = 16'd1;     end
            default: begin
               obits = OBITS_W'($urandom_range(0, 31));
               gain  = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                   : GAIN_W'($urandom_range(0, 65535));
            end
         endcase
         wait_for_drain();
         set_config(obits, gain);
         // back-to-back stretches on some phases
         idle_max = (phase == 3 || phase == 8) ? 0 : IDLE_MAX;
         // a few phases hammer two channels so the history is reused often
         ch_hi = (phase % 3 == 1) ? 1 : CHANNELS - 1;
         for (k = 0; k < 142; k++) begin
            if (k == 71 && phase % 4 == 2)
               wait_for_drain();
            send_request(CH_W'($urandom_range(0, ch_hi)), pick_sample(), pick_noise());
         end
      end
      idle_max = IDLE_MAX;
   endtask

   // Main sequence
   initial begin
      int ch;
      for (ch = 0; ch < CHANNELS; ch++) begin
         hist_noise[ch]   = '0;
         hist_err_new[ch] = '0;
         hist_err_old[ch] = '0;
      end
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_channel   = '0;
      req_sample_in = '0;
      req_noise     = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_word_length_limits();
      test_gain_above_one();
      test_random_traffic();
      wait_for_drain();

      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
